>>> hdl/rexf_pkg.sv
package rexf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int EXP_DEPTH_DEF = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RADIUS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_TIME = 3'd5;

    // exp(-16*idx/depth): step factor from a Taylor series in Q.32, entries
    // chained with round to nearest, final value rounded to frac bits.
    function automatic logic [63:0] exp_entry(int unsigned log2_depth,
                                               int unsigned frac,
                                               int unsigned idx);
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] b;
        logic [63:0] v;
        s   = 64'd16 << (32 - log2_depth);
        t   = 64'd1 << 32;
        pos = t;
        neg = 64'd0;
        for (int n = 1; n <= 24; n++)
        begin
            t = ((t * s) >> 32) / 64'(n);
            if (n[0])
                neg = neg + t;
            else
                pos = pos + t;
        end
        b = pos - neg;
        v = 64'd1 << 32;
        for (int k = 0; k < idx; k++)
        begin
            v = (v * b + (64'd1 << 31)) >> 32;
        end
        return (v + (64'd1 << (31 - frac))) >> (32 - frac);
    endfunction

endpackage

>>> hdl/radial_explosion_force_unit.sv
// Radial explosion force unit.
// Input stream (s_*): one body per item - position, inverse mass and time
// since the blast began. Output stream (m_*): one item per body, in order,
// with the force vector and an applied flag.
// Configuration: cfg_we/cfg_index/cfg_data write the centre, strength, max
// radius and decay time; write only while no body is in flight.
// Throughput: one body per cycle while the output is taken. Every step is
// a register stage: 62 restoring-divide stages for the blast radius (the
// longest of the three digit-serial units, sqrt and exp argument run
// beside it), a short exp table/interpolate and multiply section, then 33
// divide stages for the force quotient.
// Stall: the whole pipe moves as one; when the output item is not taken,
// every stage holds and s_tready drops, so nothing is lost or repeated.
// Reset: all valid bits clear; centre is 0, strength, max radius and decay
// time are 1.0. The exp table is a constant ROM, nothing to initialize.
// EXP_TABLE_DEPTH must be a power of two.
module radial_explosion_force_unit
#(
    parameter int FRAC_BITS       = rexf_pkg::FRAC_BITS_DEF,
    parameter int EXP_TABLE_DEPTH = rexf_pkg::EXP_DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rexf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rexf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], inverse_mass[126:96],
    // elapsed_time[157:127], zero pad
    input  logic [159:0]                    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // force_x[31:0], force_y[63:32], force_z[95:64], applied[96], zero pad
    output logic [103:0]                    m_tdata
);

    localparam int LD       = $clog2(EXP_TABLE_DEPTH);
    localparam int XW       = FRAC_BITS + 4;      // exp argument, below 16.0
    localparam int EW       = FRAC_BITS + 1;      // exp value, up to 1.0
    localparam int KW       = 31 + EW;            // strength * exp
    localparam int KLO      = 24;
    localparam int KHI      = KW - KLO;
    localparam int NW       = KW + 32;            // force numerator
    localparam int SW       = 66;                 // sum of squares
    localparam int SQ_STEPS = 33;
    localparam int SQR_W    = 35;
    localparam int BR_STEPS = 62;
    localparam int EX_STEPS = XW;
    localparam int ITER     = BR_STEPS;
    localparam int Q_STEPS  = 33;
    localparam int RW0      = NW - Q_STEPS;
    localparam int NST      = 3 + ITER + 6 + Q_STEPS + 2;

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic             imm;
        logic [30:0]      el;
        logic [30:0]      dt;
        logic [2:0][63:0] sq;
        logic [61:0]      mrel;
        logic             sat;
    } fr_t;

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic             imm;
        logic             sat;
        logic             zero;
        logic [30:0]      dt;
        logic [SW-1:0]    sum;
        logic [SW-1:0]    rad;
        logic [32:0]      root;
        logic [SQR_W-1:0] sqrem;
        logic [61:0]      br_num;
        logic [30:0]      br_rem;
        logic [61:0]      br_q;
        logic [XW-1:0]    ex_num;
        logic [30:0]      ex_rem;
        logic [XW-1:0]    ex_q;
    } it_t;

    typedef struct packed {
        logic [2:0][31:0]     mag;
        logic [2:0]           neg;
        logic                 app;
        logic                 zero;
        logic [SW-1:0]        sum;
        logic [EW-1:0]        a;
        logic [EW-1:0]        diff;
        logic [XW-1:0]        fr;
        logic [EW+XW-1:0]     prod;
        logic [EW-1:0]        e;
        logic [KW-1:0]        ke;
        logic [2:0][KLO+31:0] pl;
        logic [2:0][KHI+31:0] ph;
        logic [2:0][NW-1:0]   num;
    } bk_t;

    typedef struct packed {
        logic [2:0]        neg;
        logic              app;
        logic              zero;
        logic [SW-1:0]     sum;
        logic [2:0][SW-1:0] rem;
        logic [2:0][32:0]  nlo;
        logic [2:0][32:0]  q;
        logic [2:0]        ovf;
    } dv_t;

    // configuration
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [30:0]        strength_reg, max_radius_reg, decay_time_reg;

    // pipeline control
    logic               adv;
    logic [NST-1:0]     vld_reg, vld_next;

    fr_t   s1_reg, s1_next, s2_reg, s2_next;
    it_t   it_reg  [0:ITER];
    it_t   it_next [0:ITER];
    bk_t   bk_reg  [1:6];
    bk_t   bk_next [1:6];
    dv_t   dv_reg  [0:Q_STEPS];
    dv_t   dv_next [0:Q_STEPS];
    logic [96:0] out_reg, out_next;

    logic [EW-1:0] exp_rom [0:EXP_TABLE_DEPTH];

    genvar g;
    generate
        for (g = 0; g <= EXP_TABLE_DEPTH; g++)
        begin : g_rom
            assign exp_rom[g] = EW'(rexf_pkg::exp_entry(LD, FRAC_BITS, g));
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg         <= '0;
            cy_reg         <= '0;
            cz_reg         <= '0;
            strength_reg   <= 31'(1) << FRAC_BITS;
            max_radius_reg <= 31'(1) << FRAC_BITS;
            decay_time_reg <= 31'(1) << FRAC_BITS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rexf_pkg::REG_CENTRE_X:   cx_reg         <= cfg_data;
                rexf_pkg::REG_CENTRE_Y:   cy_reg         <= cfg_data;
                rexf_pkg::REG_CENTRE_Z:   cz_reg         <= cfg_data;
                rexf_pkg::REG_STRENGTH:   strength_reg   <= cfg_data[30:0];
                rexf_pkg::REG_MAX_RADIUS: max_radius_reg <= cfg_data[30:0];
                rexf_pkg::REG_DECAY_TIME: decay_time_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // whole pipe advances when the output slot is free or being taken
    assign adv      = !vld_reg[NST-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = {7'd0, out_reg};
    assign vld_next = {vld_reg[NST-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // stage 1: offsets and magnitudes
    always_comb
    begin
        logic signed [32:0] d [3];
        s1_next = '0;
        d[0] = {s_tdata[31], s_tdata[31:0]}   - {cx_reg[31], cx_reg};
        d[1] = {s_tdata[63], s_tdata[63:32]}  - {cy_reg[31], cy_reg};
        d[2] = {s_tdata[95], s_tdata[95:64]}  - {cz_reg[31], cz_reg};
        for (int k = 0; k < 3; k++)
        begin
            s1_next.neg[k] = d[k][32];
            s1_next.mag[k] = d[k][32] ? 32'(-d[k]) : 32'(d[k]);
        end
        s1_next.imm = (s_tdata[126:96] == 31'd0);
        s1_next.el  = s_tdata[157:127];
        s1_next.dt  = (decay_time_reg == 31'd0) ? 31'd1 : decay_time_reg;
    end

    // stage 2: squares, radius numerator, exp saturation
    always_comb
    begin
        s2_next = s1_reg;
        for (int k = 0; k < 3; k++)
            s2_next.sq[k] = s1_reg.mag[k] * s1_reg.mag[k];
        s2_next.mrel = max_radius_reg * s1_reg.el;
        s2_next.sat  = {4'd0, s1_reg.el} >= {s1_reg.dt, 4'd0};
    end

    // iteration entry: sum of squares, seed the three serial units
    always_comb
    begin
        it_next[0]        = '0;
        it_next[0].mag    = s2_reg.mag;
        it_next[0].neg    = s2_reg.neg;
        it_next[0].imm    = s2_reg.imm;
        it_next[0].sat    = s2_reg.sat;
        it_next[0].dt     = s2_reg.dt;
        it_next[0].sum    = SW'(s2_reg.sq[0]) + SW'(s2_reg.sq[1]) + SW'(s2_reg.sq[2]);
        it_next[0].zero   = (it_next[0].sum == '0);
        it_next[0].rad    = it_next[0].sum;
        it_next[0].br_num = s2_reg.mrel;
        it_next[0].ex_rem = s2_reg.el >> 4;
        it_next[0].ex_num = XW'({s2_reg.el[3:0], {FRAC_BITS{1'b0}}});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg     <= s1_next;
            s2_reg     <= s2_next;
            it_reg[0]  <= it_next[0];
        end
    end

    // one digit per stage: sqrt (2 bits in), radius and exp quotients
    generate
        for (g = 1; g <= ITER; g++)
        begin : g_it
            always_comb
            begin
                logic [SQR_W+1:0] st;
                logic [SQR_W+1:0] trial;
                logic [31:0]      bt;
                logic [31:0]      et;
                it_next[g] = it_reg[g-1];
                st    = {it_reg[g-1].sqrem, it_reg[g-1].rad[SW-1:SW-2]};
                trial = (SQR_W+2)'({it_reg[g-1].root, 2'b01});
                bt    = {it_reg[g-1].br_rem, it_reg[g-1].br_num[61]};
                et    = {it_reg[g-1].ex_rem, it_reg[g-1].ex_num[XW-1]};
                if (g <= SQ_STEPS)
                begin
                    it_next[g].rad = it_reg[g-1].rad << 2;
                    if (st >= trial)
                    begin
                        it_next[g].sqrem = SQR_W'(st - trial);
                        it_next[g].root  = {it_reg[g-1].root[31:0], 1'b1};
                    end
                    else
                    begin
                        it_next[g].sqrem = SQR_W'(st);
                        it_next[g].root  = {it_reg[g-1].root[31:0], 1'b0};
                    end
                end
                if (g <= BR_STEPS)
                begin
                    it_next[g].br_num = it_reg[g-1].br_num << 1;
                    if (bt >= {1'b0, it_reg[g-1].dt})
                    begin
                        it_next[g].br_rem = 31'(bt - {1'b0, it_reg[g-1].dt});
                        it_next[g].br_q   = {it_reg[g-1].br_q[60:0], 1'b1};
                    end
                    else
                    begin
                        it_next[g].br_rem = bt[30:0];
                        it_next[g].br_q   = {it_reg[g-1].br_q[60:0], 1'b0};
                    end
                end
                if (g <= EX_STEPS)
                begin
                    it_next[g].ex_num = it_reg[g-1].ex_num << 1;
                    if (et >= {1'b0, it_reg[g-1].dt})
                    begin
                        it_next[g].ex_rem = 31'(et - {1'b0, it_reg[g-1].dt});
                        it_next[g].ex_q   = {it_reg[g-1].ex_q[XW-2:0], 1'b1};
                    end
                    else
                    begin
                        it_next[g].ex_rem = et[30:0];
                        it_next[g].ex_q   = {it_reg[g-1].ex_q[XW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    it_reg[g] <= it_next[g];
            end
        end
    endgenerate

    // back 1: blast test, exp table lookup
    always_comb
    begin
        logic [LD-1:0] idx;
        logic [EW-1:0] c;
        bk_next[1]      = '0;
        bk_next[1].mag  = it_reg[ITER].mag;
        bk_next[1].neg  = it_reg[ITER].neg;
        bk_next[1].zero = it_reg[ITER].zero;
        bk_next[1].sum  = it_reg[ITER].sum;
        bk_next[1].app  = !it_reg[ITER].imm &&
                          ({29'd0, it_reg[ITER].root} < it_reg[ITER].br_q);
        idx = it_reg[ITER].ex_q[XW-1 -: LD];
        if (it_reg[ITER].sat)
        begin
            bk_next[1].a  = exp_rom[EXP_TABLE_DEPTH];
            c             = exp_rom[EXP_TABLE_DEPTH];
            bk_next[1].fr = '0;
        end
        else
        begin
            bk_next[1].a  = exp_rom[idx];
            c             = exp_rom[(LD+1)'(idx) + (LD+1)'(1)];
            bk_next[1].fr = XW'({it_reg[ITER].ex_q, {LD{1'b0}}});
        end
        bk_next[1].diff = (bk_next[1].a >= c) ? bk_next[1].a - c : '0;
    end

    // back 2: interpolation product
    always_comb
    begin
        bk_next[2]      = bk_reg[1];
        bk_next[2].prod = bk_reg[1].diff * bk_reg[1].fr;
    end

    // back 3: interpolated exp
    always_comb
    begin
        bk_next[3]   = bk_reg[2];
        bk_next[3].e = bk_reg[2].a - EW'(bk_reg[2].prod >> XW);
    end

    // back 4: strength scale
    always_comb
    begin
        bk_next[4]    = bk_reg[3];
        bk_next[4].ke = strength_reg * bk_reg[3].e;
    end

    // back 5: partial products of ke * |d|
    always_comb
    begin
        bk_next[5] = bk_reg[4];
        for (int k = 0; k < 3; k++)
        begin
            bk_next[5].pl[k] = bk_reg[4].ke[KLO-1:0] * bk_reg[4].mag[k];
            bk_next[5].ph[k] = bk_reg[4].ke[KW-1:KLO] * bk_reg[4].mag[k];
        end
    end

    // back 6: numerator
    always_comb
    begin
        bk_next[6] = bk_reg[5];
        for (int k = 0; k < 3; k++)
            bk_next[6].num[k] = (NW'(bk_reg[5].ph[k]) << KLO) + NW'(bk_reg[5].pl[k]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bk_reg[1] <= bk_next[1];
            for (int n = 2; n <= 6; n++)
                bk_reg[n] <= bk_next[n];
        end
    end

    // divide entry: overflow when quotient reaches 2^33
    always_comb
    begin
        logic [RW0-1:0] r0;
        dv_next[0]      = '0;
        dv_next[0].neg  = bk_reg[6].neg;
        dv_next[0].app  = bk_reg[6].app;
        dv_next[0].zero = bk_reg[6].zero;
        dv_next[0].sum  = bk_reg[6].sum;
        for (int k = 0; k < 3; k++)
        begin
            r0 = bk_reg[6].num[k][NW-1:Q_STEPS];
            dv_next[0].ovf[k] = (SW'(r0) >= bk_reg[6].sum);
            dv_next[0].rem[k] = SW'(r0);
            dv_next[0].nlo[k] = bk_reg[6].num[k][Q_STEPS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            dv_reg[0] <= dv_next[0];
    end

    generate
        for (g = 1; g <= Q_STEPS; g++)
        begin : g_dv
            always_comb
            begin
                logic [SW:0] t;
                dv_next[g] = dv_reg[g-1];
                for (int k = 0; k < 3; k++)
                begin
                    t = {dv_reg[g-1].rem[k], dv_reg[g-1].nlo[k][32]};
                    dv_next[g].nlo[k] = dv_reg[g-1].nlo[k] << 1;
                    if (t >= {1'b0, dv_reg[g-1].sum})
                    begin
                        dv_next[g].rem[k] = SW'(t - {1'b0, dv_reg[g-1].sum});
                        dv_next[g].q[k]   = {dv_reg[g-1].q[k][31:0], 1'b1};
                    end
                    else
                    begin
                        dv_next[g].rem[k] = t[SW-1:0];
                        dv_next[g].q[k]   = {dv_reg[g-1].q[k][31:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    dv_reg[g] <= dv_next[g];
            end
        end
    endgenerate

    // output: saturate to signed 32 bits
    always_comb
    begin
        logic [32:0] m;
        out_next     = '0;
        out_next[96] = dv_reg[Q_STEPS].app;
        for (int k = 0; k < 3; k++)
        begin
            m = dv_reg[Q_STEPS].ovf[k] ? '1 : dv_reg[Q_STEPS].q[k];
            if (dv_reg[Q_STEPS].app && !dv_reg[Q_STEPS].zero)
            begin
                if (dv_reg[Q_STEPS].neg[k])
                    out_next[k*32 +: 32] = (m > 33'h0_8000_0000) ? 32'h8000_0000
                                                                 : 32'(-m);
                else
                    out_next[k*32 +: 32] = (m > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF
                                                                 : m[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    // a body outside the blast or immovable carries no force
    a_no_force: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[96] |-> m_tdata[95:0] == 96'd0)
        else $error("force on an unapplied item");

    // a stalled output freezes the valid bit of every stage
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    // an accepted body enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted item lost");

endmodule

>>> verif/radial_explosion_force_unit_test.sv
module radial_explosion_force_unit_test;

    localparam int FRAC   = 16;
    localparam int DEPTH  = 256;
    localparam int SPAN_Q = 16 << FRAC;          // exp argument where the table ends
    localparam int DRAIN  = 120;                 // extra wait after the last owed force has arrived
    // index with no register behind it
    localparam logic [rexf_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd6;

    // packed so that m_tdata[96:0] lands field by field: fx lowest, applied on top
    typedef struct packed
    {
        logic               applied;
        logic signed [31:0] fz;
        logic signed [31:0] fy;
        logic signed [31:0] fx;
    } force_t;

    // Holds the forces still owed by the block, in acceptance order.
    class force_scoreboard;
        force_t owed[$];
        int     mismatches = 0;
        int     checked    = 0;

        function void note_body(force_t f);
            owed.push_back(f);
        endfunction

        function void check_force(force_t got);
            force_t want;
            checked++;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected force item: x=%h y=%h z=%h applied=%b",
                             got.fx, got.fy, got.fz, got.applied);
                return;
            end
            want = owed.pop_front();
            if (got.fx !== want.fx || got.fy !== want.fy || got.fz !== want.fz
                || got.applied !== want.applied)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("force #%0d: expected x=%h y=%h z=%h ap=%b, got x=%h y=%h z=%h ap=%b",
                             checked, want.fx, want.fy, want.fz, want.applied,
                             got.fx, got.fy, got.fz, got.applied);
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [rexf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rexf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [159:0]                    s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [103:0]                    m_tdata;

    radial_explosion_force_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // hard stop in case the pipe hangs
    initial
    begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    force_scoreboard sb = new();

    // shadow of the configuration registers
    longint      centre_x = 0, centre_y = 0, centre_z = 0;
    logic [30:0] strength = 31'h10000, max_radius = 31'h10000, decay_time = 31'h10000;

    logic [63:0] exp_rom [0:DEPTH];
    int          send_idle_pct = 0, recv_idle_pct = 0;
    int          bodies_sent = 0, applied_seen = 0, cfg_sets = 0;

    // exp(-16 i / DEPTH): Q.32 step factor from a Taylor series, chained products
    function automatic void fill_exp_rom();
        logic [63:0] step, term, plus, minus, factor, acc;
        step  = (64'd16 << 32) / DEPTH;
        term  = 64'd1 << 32;
        plus  = term;
        minus = 0;
        for (int n = 1; n <= 24; n++)
        begin
            term = ((term * step) >> 32) / n;
            if (n % 2 == 1)
                minus += term;
            else
                plus += term;
        end
        factor = plus - minus;
        acc = 64'd1 << 32;
        for (int i = 0; i <= DEPTH; i++)
        begin
            exp_rom[i] = (acc + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
            acc = (acc * factor + (64'd1 << 31)) >> 32;
        end
    endfunction

    function automatic logic [63:0] decay_factor(logic [63:0] el, logic [63:0] dt);
        logic [63:0] arg, scaled, idx, frac_part, lo, hi;
        arg = (el << FRAC) / dt;
        if (arg >= SPAN_Q)
            return exp_rom[DEPTH];
        scaled    = arg * DEPTH;
        idx       = scaled / SPAN_Q;
        frac_part = scaled % SPAN_Q;
        lo = exp_rom[idx];
        hi = exp_rom[idx + 1];
        if (lo < hi)
            return lo;
        return lo - ((lo - hi) * frac_part) / SPAN_Q;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [127:0] v);
        logic [63:0] rem, root;
        rem  = 0;
        root = 0;
        for (int i = 33; i >= 0; i--)
        begin
            rem = (rem << 2) | 64'(v[2*i +: 2]);
            if (rem >= 4 * root + 1)
            begin
                rem  = rem - (4 * root + 1);
                root = 2 * root + 1;
            end
            else
                root = 2 * root;
        end
        return root;
    endfunction

    function automatic logic signed [31:0] clamp_component(logic [127:0] q, bit neg);
        if (neg)
        begin
            if (q > 128'h8000_0000)
                q = 128'h8000_0000;
            return 32'(-q);
        end
        return (q > 128'h7fff_ffff) ? 32'h7fff_ffff : 32'(q);
    endfunction

    function automatic force_t blast_force(logic [159:0] body);
        force_t      f;
        longint      off [3];
        logic [63:0] mag [3];
        logic [127:0] dist_sq, num;
        logic [63:0] el, dt, blast_r, gain;
        off[0] = longint'($signed(body[31:0]))  - centre_x;
        off[1] = longint'($signed(body[63:32])) - centre_y;
        off[2] = longint'($signed(body[95:64])) - centre_z;
        el = 64'(body[157:127]);
        dt = (decay_time == 0) ? 64'd1 : 64'(decay_time);
        f  = '0;
        if (body[126:96] == 0)
            return f;                       // immovable body
        blast_r = (64'(max_radius) * el) / dt;
        dist_sq = 0;
        for (int k = 0; k < 3; k++)
        begin
            mag[k]  = (off[k] < 0) ? 64'(-off[k]) : 64'(off[k]);
            dist_sq += 128'(mag[k]) * 128'(mag[k]);
        end
        if (floor_sqrt(dist_sq) >= blast_r)
            return f;                       // outside the blast front
        f.applied = 1'b1;
        if (dist_sq == 0)
            return f;                       // at the centre: zero offset, zero force
        gain = 64'(strength) * decay_factor(el, dt);
        num = 128'(gain) * 128'(mag[0]);
        f.fx = clamp_component(num / dist_sq, off[0] < 0);
        num = 128'(gain) * 128'(mag[1]);
        f.fy = clamp_component(num / dist_sq, off[1] < 0);
        num = 128'(gain) * 128'(mag[2]);
        f.fz = clamp_component(num / dist_sq, off[2] < 0);
        return f;
    endfunction

    // config write; only called with the pipe empty
    task automatic write_reg(logic [rexf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            rexf_pkg::REG_CENTRE_X:   centre_x   = longint'($signed(val));
            rexf_pkg::REG_CENTRE_Y:   centre_y   = longint'($signed(val));
            rexf_pkg::REG_CENTRE_Z:   centre_z   = longint'($signed(val));
            rexf_pkg::REG_STRENGTH:   strength   = val[30:0];
            rexf_pkg::REG_MAX_RADIUS: max_radius = val[30:0];
            rexf_pkg::REG_DECAY_TIME: decay_time = val[30:0];
            default: ;
        endcase
    endtask

    task automatic send_body(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [30:0] inv_mass, logic [30:0] el);
        // random idle gap before the item, valid already at the falling edge
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, el, inv_mass, pz, py, px};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_body(blast_force(s_tdata));
        bodies_sent++;
        @(negedge clk);
    endtask

    // called at a falling edge, right after the last accepted item
    task automatic drain_pipe();
        s_tvalid = 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    // receiver back-pressure, changed at the falling edge
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_force(m_tdata[96:0]);
            if (m_tdata[96])
                applied_seen++;
        end

    function automatic logic [30:0] pick31();
        case ($urandom_range(5))
            0:       return 31'h0;
            1:       return 31'h7fff_ffff;
            2:       return 31'h10000;
            3:       return 31'($urandom_range(32'h40000, 1));
            default: return 31'($urandom);
        endcase
    endfunction

    // coordinate near the centre, on a random power-of-two scale, or now and then fully random
    function automatic logic [31:0] near(longint c);
        int sh;
        sh = $urandom_range(31);
        if ($urandom_range(9) == 0)
            return $urandom;
        return 32'(c + longint'($signed($urandom)) / (longint'(1) << sh));
    endfunction

    task automatic random_body();
        logic [30:0] im, el;
        logic [63:0] dt;
        dt = (decay_time == 0) ? 64'd1 : 64'(decay_time);
        im = ($urandom_range(9) == 0) ? 31'h0 : pick31();
        case ($urandom_range(3))
            0:       el = 31'($urandom);
            1:       el = 31'(($urandom_range(1000) * dt) / 64);
            2:       el = 31'($urandom_range(3) == 0 ? 31'h7fff_ffff : dt);
            default: el = 31'($urandom_range(32'h8_0000));
        endcase
        if (im == 0 && $urandom_range(1))
            im = 31'($urandom) | 31'h1;
        send_body(near(centre_x), near(centre_y), near(centre_z), im, el);
    endtask

    initial
    begin
        fill_exp_rom();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed, reset config: blast radius equals elapsed time
        send_body(32'h0, 32'h0, 32'h0, 31'h0, 31'h8000);          // immovable
        send_body(32'h0, 32'h0, 32'h0, 31'h10000, 31'h8000);      // at the centre
        send_body(32'h0, 32'h0, 32'h0, 31'h10000, 31'h0);         // zero radius
        send_body(32'h4000, 32'h0, 32'h0, 31'h10000, 31'h8000);   // inside
        send_body(32'h8000, 32'h0, 32'h0, 31'h10000, 31'h8000);   // r equals R
        send_body(32'h0, 32'hffff_c000, 32'h0, 31'h1, 31'h8000);  // negative y
        send_body(32'h0, 32'h0, 32'h1, 31'h7fff_ffff, 31'h7fff_ffff);
        send_body(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  31'h7fff_ffff, 31'h7fff_ffff);
        send_body(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  31'h7fff_ffff, 31'h7fff_ffff);
        send_body(32'h1, 32'hffff_ffff, 32'h1, 31'h5555_5555, 31'h2a_aaaa);
        send_body(32'h100, 32'h200, 32'hffff_fd00, 31'h10000, 31'h11_0000); // past table end
        drain_pipe();

        // zero decay time, largest strength, spare index ignored
        write_reg(rexf_pkg::REG_DECAY_TIME, 32'h0);
        write_reg(rexf_pkg::REG_STRENGTH, 32'h7fff_ffff);
        write_reg(REG_SPARE, 32'hdead_beef);
        send_body(32'h1, 32'h0, 32'h0, 31'h10000, 31'h0);
        send_body(32'h1, 32'h1, 32'h0, 31'h10000, 31'h1);
        send_body(32'hffff_ffff, 32'h0, 32'h1, 31'h10000, 31'h20);
        send_body(32'h10, 32'h0, 32'h0, 31'h10000, 31'h7fff_ffff);
        drain_pipe();

        for (int ph = 0; ph < 12; ph++)
        begin
            // idling schedule: receiver-heavy, then sender-heavy, then none
            send_idle_pct = (ph < 4) ? 37 : (ph < 8) ? 50 : 0;
            recv_idle_pct = (ph < 4) ? 50 : (ph < 8) ? 37 : 0;
            write_reg(rexf_pkg::REG_CENTRE_X, (ph == 1) ? 32'h8000_0000
                                            : (ph == 2) ? 32'h7fff_ffff : $urandom);
            write_reg(rexf_pkg::REG_CENTRE_Y, (ph == 1) ? 32'h8000_0000 : $urandom);
            write_reg(rexf_pkg::REG_CENTRE_Z, (ph == 2) ? 32'h7fff_ffff : $urandom);
            write_reg(rexf_pkg::REG_STRENGTH, 32'(pick31()));
            write_reg(rexf_pkg::REG_MAX_RADIUS, (ph == 3) ? 32'h0
                                              : (ph == 5) ? 32'h7fff_ffff
                                    : 32'($urandom_range(32'h7fff_ffff, 32'h100)));
            write_reg(rexf_pkg::REG_DECAY_TIME, (ph == 4) ? 32'h7fff_ffff
                                              : (ph == 6) ? 32'h1
                                    : 32'($urandom_range(32'h40_0000, 32'h100)));
            cfg_sets++;
            repeat (136) random_body();
            drain_pipe();
        end

        $display("%0d bodies over %0d register settings plus directed cases; %0d forces applied",
                 bodies_sent, cfg_sets, applied_seen);
        $display("%0d result items checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.owed.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/rexf_pkg.sv
hdl/radial_explosion_force_unit.sv
verif/radial_explosion_force_unit_test.sv
